// ===== rtl/quoted_command_tokenizer_core_macros.svh =====
// Assertion macros used by the checker file of the tokenizer.
`ifndef QUOTED_COMMAND_TOKENIZER_CORE_MACROS_SVH
`define QUOTED_COMMAND_TOKENIZER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define QCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define QCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

// ===== rtl/qct_pkg.sv =====
`default_nettype none
package qct_pkg;

  localparam int BUF_DEPTH  = 64;
  localparam int MAX_TOKENS = 32;
  localparam int BUF_AW     = $clog2(BUF_DEPTH);
  localparam int FILL_W     = $clog2(BUF_DEPTH + 1);
  localparam int TOK_AW     = $clog2(MAX_TOKENS);
  localparam int TOK_CW     = $clog2(MAX_TOKENS + 1);
  localparam int CFG_W      = 7;
  localparam int LIM_W      = (FILL_W > CFG_W) ? FILL_W : CFG_W;
  localparam int ACT_W      = 3;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 6;
  localparam int POS_W      = 16;
  localparam int OFF_W      = 6;
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = 1;
  localparam int Q_CW       = 2;

  localparam logic [CFG_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACT_W-1:0] ACT_END    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FIND   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;

  typedef enum logic [3:0] {
    OP_APP_NUL,
    OP_APP_QUOTE,
    OP_APP_BLANK,
    OP_APP_TEXT,
    OP_END,
    OP_FIND,
    OP_READ,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/qct_front.sv =====
`default_nettype none
module qct_front (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire  [qct_pkg::ACT_W-1:0]       action,
  input  wire  [qct_pkg::CHAR_W-1:0]      char_in,
  input  wire  [qct_pkg::IDX_W-1:0]       index,
  output logic                            push_valid,
  input  wire                             push_ready,
  output qct_pkg::item_t                  push_item
);

  logic           f_valid;
  qct_pkg::item_t f_item;
  qct_pkg::item_t item_next;

  // Decode the action and sort append characters into their classes.
  always_comb begin
    item_next.ch  = char_in;
    item_next.idx = index;
    unique case (action)
      qct_pkg::ACT_APPEND: begin
        if (char_in == qct_pkg::CH_NUL) begin
          item_next.op = qct_pkg::OP_APP_NUL;
        end else if (char_in == qct_pkg::CH_QUOTE) begin
          item_next.op = qct_pkg::OP_APP_QUOTE;
        end else if (char_in == qct_pkg::CH_SPACE || char_in == qct_pkg::CH_TAB) begin
          item_next.op = qct_pkg::OP_APP_BLANK;
        end else begin
          item_next.op = qct_pkg::OP_APP_TEXT;
        end
      end
      qct_pkg::ACT_END:   item_next.op = qct_pkg::OP_END;
      qct_pkg::ACT_FIND:  item_next.op = qct_pkg::OP_FIND;
      qct_pkg::ACT_READ:  item_next.op = qct_pkg::OP_READ;
      qct_pkg::ACT_CLEAR: item_next.op = qct_pkg::OP_CLEAR;
      default:            item_next.op = qct_pkg::OP_NONE;
    endcase
  end

  assign push_valid = f_valid;
  assign push_item  = f_item;
  assign in_ready   = !f_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      f_item <= item_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qct_queue.sv =====
`default_nettype none
module qct_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             push_valid,
  output logic            push_ready,
  input  qct_pkg::item_t  push_item,
  output logic            pop_valid,
  input  wire             pop,
  output qct_pkg::item_t  pop_item
);

  qct_pkg::item_t            slots [qct_pkg::Q_DEPTH];
  logic [qct_pkg::Q_AW-1:0]  wr_ptr;
  logic [qct_pkg::Q_AW-1:0]  rd_ptr;
  logic [qct_pkg::Q_CW-1:0]  count;
  logic                      do_push;
  logic                      do_pop;

  assign push_ready = (count != qct_pkg::Q_CW'(qct_pkg::Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qct_back.sv =====
`default_nettype none
module qct_back (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_write,
  input  wire  [qct_pkg::CFG_W-1:0]    cfg_data,
  input  wire                          q_valid,
  input  qct_pkg::item_t               q_item,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         ok,
  output logic [qct_pkg::CNT_W-1:0]    token_count,
  output logic                         error_flag,
  output logic [qct_pkg::POS_W-1:0]    error_position,
  output logic [qct_pkg::OFF_W-1:0]    token_offset,
  output logic [qct_pkg::CHAR_W-1:0]   read_byte
);

  logic [qct_pkg::CHAR_W-1:0] text_mem [qct_pkg::BUF_DEPTH];
  logic [qct_pkg::BUF_AW-1:0] tok_mem  [qct_pkg::MAX_TOKENS];

  logic [qct_pkg::CFG_W-1:0]  buffer_limit;
  logic [qct_pkg::FILL_W-1:0] fill_level, fill_level_next;
  logic [qct_pkg::TOK_CW-1:0] tokens_done, tokens_done_next;
  logic                       in_quotes, in_quotes_next;
  logic                       last_sep, last_sep_next;
  logic                       error_seen, error_seen_next;
  logic [qct_pkg::POS_W-1:0]  error_at, error_at_next;
  logic [qct_pkg::POS_W-1:0]  chars_seen, chars_seen_next;

  logic                       ok_next;
  logic                       find_hit, read_hit;
  logic                       find_q, read_q;
  logic [qct_pkg::CHAR_W-1:0] text_q;
  logic [qct_pkg::BUF_AW-1:0] tok_q;

  logic                       sep_req, txt_req, end_op;
  logic                       text_we, tok_we;
  logic [qct_pkg::CHAR_W-1:0] text_wdata;
  logic [qct_pkg::LIM_W-1:0]  lim;
  logic                       full, new_tok, tok_full;
  logic [qct_pkg::POS_W-1:0]  chars_sat;

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    lim = (qct_pkg::LIM_W'(buffer_limit) < qct_pkg::LIM_W'(qct_pkg::BUF_DEPTH))
        ? qct_pkg::LIM_W'(buffer_limit) : qct_pkg::LIM_W'(qct_pkg::BUF_DEPTH);
    full      = qct_pkg::LIM_W'(fill_level) >= lim;
    new_tok   = (fill_level == '0) || last_sep;
    tok_full  = tokens_done >= qct_pkg::TOK_CW'(qct_pkg::MAX_TOKENS);
    chars_sat = (chars_seen == '1) ? chars_seen : chars_seen + 1'b1;

    fill_level_next  = fill_level;
    tokens_done_next = tokens_done;
    in_quotes_next   = in_quotes;
    last_sep_next    = last_sep;
    error_seen_next  = error_seen;
    error_at_next    = error_at;
    chars_seen_next  = chars_seen;
    ok_next    = 1'b0;
    find_hit   = 1'b0;
    read_hit   = 1'b0;
    sep_req    = 1'b0;
    txt_req    = 1'b0;
    end_op     = 1'b0;
    text_we    = 1'b0;
    tok_we     = 1'b0;
    text_wdata = q_item.ch;

    unique case (q_item.op)
      qct_pkg::OP_APP_NUL: begin
        chars_seen_next = chars_sat;
        ok_next         = !error_seen;
      end
      qct_pkg::OP_APP_QUOTE: begin
        chars_seen_next = chars_sat;
        if (!error_seen) begin
          in_quotes_next = !in_quotes;
          ok_next        = 1'b1;
        end
      end
      qct_pkg::OP_APP_BLANK: begin
        chars_seen_next = chars_sat;
        if (!error_seen) begin
          if (in_quotes) begin
            txt_req = 1'b1;
          end else if (new_tok) begin
            ok_next = 1'b1;
          end else begin
            sep_req = 1'b1;
          end
        end
      end
      qct_pkg::OP_APP_TEXT: begin
        chars_seen_next = chars_sat;
        txt_req         = !error_seen;
      end
      qct_pkg::OP_END: begin
        if (!error_seen) begin
          end_op = 1'b1;
          if (in_quotes) begin
            error_seen_next = 1'b1;
            error_at_next   = chars_seen;
          end else if (!new_tok) begin
            sep_req = 1'b1;
          end
        end
      end
      qct_pkg::OP_FIND: begin
        find_hit = !error_seen && (32'(q_item.idx) < 32'(tokens_done));
        ok_next  = find_hit;
      end
      qct_pkg::OP_READ: begin
        read_hit = 32'(q_item.idx) < 32'(fill_level);
        ok_next  = read_hit;
      end
      qct_pkg::OP_CLEAR: begin
        fill_level_next  = '0;
        tokens_done_next = '0;
        in_quotes_next   = 1'b0;
        last_sep_next    = 1'b0;
        error_seen_next  = 1'b0;
        error_at_next    = '0;
        chars_seen_next  = '0;
        ok_next          = 1'b1;
      end
      default: begin
      end
    endcase

    // A refused store records the position of the character being handled,
    // which is the count before this character was added.
    if (sep_req) begin
      if (full) begin
        error_seen_next = 1'b1;
        error_at_next   = chars_seen;
      end else begin
        text_we          = 1'b1;
        text_wdata       = qct_pkg::CH_NUL;
        fill_level_next  = fill_level + 1'b1;
        tokens_done_next = tokens_done + 1'b1;
        last_sep_next    = 1'b1;
        ok_next          = 1'b1;
      end
    end
    if (txt_req) begin
      if (full || (new_tok && tok_full)) begin
        error_seen_next = 1'b1;
        error_at_next   = chars_seen;
      end else begin
        text_we         = 1'b1;
        tok_we          = new_tok;
        fill_level_next = fill_level + 1'b1;
        last_sep_next   = 1'b0;
        ok_next         = 1'b1;
      end
    end
    if (end_op) begin
      ok_next = !error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_limit <= qct_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      buffer_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      fill_level  <= '0;
      tokens_done <= '0;
      in_quotes   <= 1'b0;
      last_sep    <= 1'b0;
      error_seen  <= 1'b0;
      error_at    <= '0;
      chars_seen  <= '0;
    end else begin
      if (q_pop) begin
        out_valid   <= 1'b1;
        fill_level  <= fill_level_next;
        tokens_done <= tokens_done_next;
        in_quotes   <= in_quotes_next;
        last_sep    <= last_sep_next;
        error_seen  <= error_seen_next;
        error_at    <= error_at_next;
        chars_seen  <= chars_seen_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (q_pop) begin
      ok             <= ok_next;
      token_count    <= qct_pkg::CNT_W'(tokens_done_next);
      error_flag     <= error_seen_next;
      error_position <= error_at_next;
      find_q         <= find_hit;
      read_q         <= read_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && text_we) begin
      text_mem[qct_pkg::BUF_AW'(fill_level)] <= text_wdata;
    end
    if (q_pop && tok_we) begin
      tok_mem[qct_pkg::TOK_AW'(tokens_done)] <= qct_pkg::BUF_AW'(fill_level);
    end
    if (q_pop) begin
      text_q <= text_mem[qct_pkg::BUF_AW'(q_item.idx)];
      tok_q  <= tok_mem[qct_pkg::TOK_AW'(q_item.idx)];
    end
  end

  assign token_offset = find_q ? qct_pkg::OFF_W'(tok_q) : '0;
  assign read_byte    = read_q ? text_q : '0;

endmodule
`default_nettype wire

// ===== rtl/quoted_command_tokenizer_core.sv =====
// Quoted command tokenizer core.
// The input channel (in_valid/in_ready) carries one transaction per action:
// append a character, end the command, look up a token start, read a stored
// byte, or clear. Every input transaction yields exactly one result
// transaction on out_valid/out_ready, in order, carrying ok, the token
// count, the error flag and position, and the looked-up offset or byte.
// An accepted transaction is decoded in the front register, waits in a
// two-entry queue and is executed by the back end, whose result register
// is loaded together with the registered memory read data. While out_ready
// stays high, one transaction per cycle is sustained: the back end updates
// its state and the text and token-start memories once per action.
// When the receiver stalls, the result register holds, the queue fills and
// in_ready drops once the front register cannot drain. The buffer limit is
// written through cfg_write/cfg_data with no wait and is kept by a clear.
// A synchronous reset empties the pipeline, sets the limit to 64 bytes and
// returns the tokenizer to an empty command with no error; the memories
// are not cleared, as only written entries are ever read back.
`default_nettype none
module quoted_command_tokenizer_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_write,
  input  wire  [qct_pkg::CFG_W-1:0]    cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [qct_pkg::ACT_W-1:0]    action,
  input  wire  [qct_pkg::CHAR_W-1:0]   char_in,
  input  wire  [qct_pkg::IDX_W-1:0]    index,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         ok,
  output logic [qct_pkg::CNT_W-1:0]    token_count,
  output logic                         error_flag,
  output logic [qct_pkg::POS_W-1:0]    error_position,
  output logic [qct_pkg::OFF_W-1:0]    token_offset,
  output logic [qct_pkg::CHAR_W-1:0]   read_byte
);

  // Decoded transaction handed from the front register into the queue.
  logic           push_valid;
  logic           push_ready;
  qct_pkg::item_t push_item;

  // Head of the queue as seen by the back end.
  logic           q_valid;
  logic           q_pop;
  qct_pkg::item_t q_item;

  qct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .char_in    (char_in),
    .index      (index),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // The two-entry queue lets the front keep taking transactions while
  // the back end is held by a stalled receiver.
  qct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  qct_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .token_count    (token_count),
    .error_flag     (error_flag),
    .error_position (error_position),
    .token_offset   (token_offset),
    .read_byte      (read_byte)
  );

endmodule
`default_nettype wire

// ===== rtl/qct_checker.sv =====
`default_nettype none
`include "quoted_command_tokenizer_core_macros.svh"
module qct_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire                          ok,
  input wire [qct_pkg::CNT_W-1:0]     token_count,
  input wire                          error_flag,
  input wire [qct_pkg::POS_W-1:0]     error_position,
  input wire [qct_pkg::OFF_W-1:0]     token_offset,
  input wire [qct_pkg::CHAR_W-1:0]    read_byte
);

  // A pending result is not withdrawn.
  `QCT_ASSERT_NEXT(a_out_held, out_valid && !out_ready, out_valid)
  // An offset or byte only comes back for a successful query.
  `QCT_ASSERT_NOW(a_query_gated, out_valid && (token_offset != '0 || read_byte != '0), ok)
  // The token count never passes the token limit.
  `QCT_ASSERT_NOW(a_count_range, out_valid, token_count <= qct_pkg::CNT_W'(qct_pkg::MAX_TOKENS))
  // Without an error there is no error position.
  `QCT_ASSERT_NOW(a_pos_clean, out_valid && !error_flag, error_position == '0)

endmodule

bind quoted_command_tokenizer_core qct_checker u_qct_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .ok             (ok),
  .token_count    (token_count),
  .error_flag     (error_flag),
  .error_position (error_position),
  .token_offset   (token_offset),
  .read_byte      (read_byte)
);
`default_nettype wire
